[hdl/pi_ci_pkg.sv]
// Shared types, constants and fixed-point helpers for the PI controller.
`timescale 1ns / 1ps

package pi_ci_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int OPND_W = DATA_W + 1;
  localparam int PROD_W = 2 * OPND_W;
  localparam int REG_IDX_W = 2;
  localparam int ADDR_W = REG_IDX_W + 2;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] DATA_MAX_EXT =
    {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] DATA_MIN_EXT =
    {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  localparam logic signed [DATA_W-1:0] PROP_GAIN_RST = DATA_W'(1 << FRAC_W);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_LIMIT_LOW  = 2'd2,
    REG_LIMIT_HIGH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] limit_low;
    logic signed [DATA_W-1:0] limit_high;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_HOLD  = 2'd0,
    ALU_MUL   = 2'd1,
    ALU_SCALE = 2'd2,
    ALU_ADD   = 2'd3
  } alu_op_t;

  // Clip a wide signed value to the data range.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > DATA_MAX_EXT) begin
      r = DATA_MAX;
    end else if (v < DATA_MIN_EXT) begin
      r = DATA_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [OPND_W-1:0] sext_opnd(input logic signed [DATA_W-1:0] v);
    return {v[DATA_W-1], v};
  endfunction

endpackage

[hdl/pi_ci_cfg_regs.sv]
// APB register file holding the controller gains and output limits.
`timescale 1ns / 1ps

module pi_ci_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pi_ci_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output pi_ci_pkg::cfg_t              cfg
);
  import pi_ci_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain  <= PROP_GAIN_RST;
      cfg_r.integ_gain <= '0;
      cfg_r.limit_low  <= DATA_MIN;
      cfg_r.limit_high <= DATA_MAX;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:  cfg_r.prop_gain  <= pwdata;
        REG_INTEG_GAIN: cfg_r.integ_gain <= pwdata;
        REG_LIMIT_LOW:  cfg_r.limit_low  <= pwdata;
        REG_LIMIT_HIGH: cfg_r.limit_high <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:  prdata = cfg_r.prop_gain;
      REG_INTEG_GAIN: prdata = cfg_r.integ_gain;
      REG_LIMIT_LOW:  prdata = cfg_r.limit_low;
      REG_LIMIT_HIGH: prdata = cfg_r.limit_high;
    endcase
  end

endmodule

[hdl/pi_ci_alu.sv]
// Shared arithmetic unit: multiply, fixed-point rescale with saturation, saturating add.
`timescale 1ns / 1ps

module pi_ci_alu (
  input  logic                                clk,
  input  pi_ci_pkg::alu_op_t                  op,
  input  logic signed [pi_ci_pkg::OPND_W-1:0] opnd_a,
  input  logic signed [pi_ci_pkg::OPND_W-1:0] opnd_b,
  output logic signed [pi_ci_pkg::PROD_W-1:0] result
);
  import pi_ci_pkg::*;

  logic signed [PROD_W-1:0] res_r;
  logic signed [PROD_W-1:0] res_nxt;
  logic signed [PROD_W-1:0] shifted;
  logic signed [OPND_W:0]   sum;

  // The arithmetic shift floors toward minus infinity.
  assign shifted = res_r >>> FRAC_W;
  assign sum     = {opnd_a[OPND_W-1], opnd_a} + {opnd_b[OPND_W-1], opnd_b};

  always_comb begin
    unique case (op)
      ALU_HOLD:  res_nxt = res_r;
      ALU_MUL:   res_nxt = opnd_a * opnd_b;
      ALU_SCALE: res_nxt = PROD_W'(sat_data(shifted));
      ALU_ADD:   res_nxt = PROD_W'(sat_data(PROD_W'(sum)));
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

[hdl/pi_controller_conditional_integration_unit.sv]
// Top level of the PI controller with conditional-integration anti-windup.
`timescale 1ns / 1ps

// Each input beat carries a setpoint and a feedback sample in signed Q16.16 and
// yields exactly one result beat with the raw drive, the drive clamped to the
// configured limits, and a saturation flag. The proportional term is
// prop_gain * (setpoint - feedback); the integral grows by integ_gain times that
// term only when the previous result was not saturated, otherwise it is frozen.
// Every product is floored by 16 fractional bits and saturated to 32 bits, and the
// integral and the sum saturate the same way. All arithmetic runs through one
// shared multiply/rescale/add unit under a small sequencer. A result is loaded into
// the output register in S_OUT, which follows S_MUL_P, S_SCALE_P, S_MUL_I, S_SCALE_I,
// S_ACC and S_SUM when the integral updates and S_MUL_P, S_SCALE_P and S_SUM when it
// is frozen; in_tready is low from acceptance until that load. The
// finished result sits in an output register, so the next sample is accepted while
// it waits; if a second result finishes before the first is taken, the sequencer
// holds it until the output register frees up. Configuration is written over the
// APB port (registers at byte offsets 0, 4, 8, 12: prop_gain, integ_gain,
// limit_low, limit_high) and should only change while the block is idle. When
// limit_low exceeds limit_high, the upper limit is tested first.
module pi_controller_conditional_integration_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: [31:0] setpoint, [63:32] feedback.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // Result stream: [31:0] drive_raw, [63:32] drive_clamped.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  // [0] saturated.
  output logic        out_tuser,
  // Configuration port.
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pi_ci_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import pi_ci_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,
    S_SCALE_P,
    S_MUL_I,
    S_SCALE_I,
    S_ACC,
    S_SUM,
    S_OUT
  } state_t;

  state_t state_r;

  cfg_t cfg;

  logic signed [OPND_W-1:0] err_r;
  logic signed [DATA_W-1:0] up_r;
  logic signed [DATA_W-1:0] integral_r;
  logic                     was_sat_r;

  logic                     out_tvalid_r;
  logic [63:0]              out_tdata_r;
  logic                     out_tuser_r;

  alu_op_t                  alu_op;
  logic signed [OPND_W-1:0] alu_a;
  logic signed [OPND_W-1:0] alu_b;
  logic signed [PROD_W-1:0] alu_res;
  logic signed [DATA_W-1:0] res_lo;

  logic signed [DATA_W-1:0] clamped;
  logic                     sat_flag;
  logic                     in_beat;
  logic                     out_beat;
  logic                     load_out;

  pi_ci_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pi_ci_alu u_alu (
    .clk    (clk),
    .op     (alu_op),
    .opnd_a (alu_a),
    .opnd_b (alu_b),
    .result (alu_res)
  );

  // After a rescale or add the unit holds a value already clipped to 32 bits.
  assign res_lo = alu_res[DATA_W-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_beat  = out_tvalid_r && out_tready;
  assign load_out  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // Operand steering for the shared unit. In the sum step, the frozen path
  // still has the proportional term in the unit, while the integrating path has
  // the fresh integral there and the proportional term saved in up_r.
  always_comb begin
    alu_op = ALU_HOLD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_r)
      S_IDLE, S_OUT: begin
        alu_op = ALU_HOLD;
      end
      S_MUL_P: begin
        alu_op = ALU_MUL;
        alu_a  = sext_opnd(cfg.prop_gain);
        alu_b  = err_r;
      end
      S_SCALE_P, S_SCALE_I: begin
        alu_op = ALU_SCALE;
      end
      S_MUL_I: begin
        alu_op = ALU_MUL;
        alu_a  = sext_opnd(cfg.integ_gain);
        alu_b  = sext_opnd(res_lo);
      end
      S_ACC: begin
        alu_op = ALU_ADD;
        alu_a  = sext_opnd(integral_r);
        alu_b  = sext_opnd(res_lo);
      end
      S_SUM: begin
        alu_op = ALU_ADD;
        alu_a  = was_sat_r ? sext_opnd(res_lo) : sext_opnd(up_r);
        alu_b  = was_sat_r ? sext_opnd(integral_r) : sext_opnd(res_lo);
      end
    endcase
  end

  // Clamp tests the upper limit first, which decides the crossed-limit case.
  always_comb begin
    if (res_lo > cfg.limit_high) begin
      clamped = cfg.limit_high;
    end else if (res_lo < cfg.limit_low) begin
      clamped = cfg.limit_low;
    end else begin
      clamped = res_lo;
    end
    sat_flag = (clamped != res_lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      integral_r   <= '0;
      was_sat_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            state_r <= S_MUL_P;
          end
        end
        S_MUL_P:   state_r <= S_SCALE_P;
        S_SCALE_P: state_r <= was_sat_r ? S_SUM : S_MUL_I;
        S_MUL_I:   state_r <= S_SCALE_I;
        S_SCALE_I: state_r <= S_ACC;
        S_ACC:     state_r <= S_SUM;
        S_SUM: begin
          if (!was_sat_r) begin
            integral_r <= res_lo;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            was_sat_r <= sat_flag;
            state_r   <= S_IDLE;
          end
        end
      endcase

      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_beat) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      err_r <= sext_opnd(in_tdata[31:0]) - sext_opnd(in_tdata[63:32]);
    end
    if (state_r == S_MUL_I) begin
      up_r <= res_lo;
    end
    if (load_out) begin
      out_tdata_r <= {clamped, res_lo};
      out_tuser_r <= sat_flag;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[hdl/pi_ci_checker.sv]
// Port-level checker for the PI controller and its bind to the top level.
`timescale 1ns / 1ps

module pi_ci_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result must hold its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  else $error("stalled result beat changed");

  // An accepted beat keeps the block busy, with in_tready low, right after acceptance.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
  else $error("input accepted again too early");

  // The saturation flag matches a difference between raw and clamped drive.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[63:32] != out_tdata[31:0])))
  else $error("saturation flag inconsistent with drive values");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
  else $error("result appeared while the block was idle");

endmodule

bind pi_controller_conditional_integration_unit pi_ci_checker u_pi_ci_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[bench/tb.sv]
// Self-checking testbench for the PI controller with conditional-integration anti-windup.
`timescale 1ns / 1ps

module tb;
  import pi_ci_pkg::*;

  // The limit sits far above what a slow but correct run needs, so it leaves a wide margin.
  localparam int LIMIT_CYCLES = 500000;
  // The long receiver hold-off fills the output register and the sequencer behind it.
  localparam int LONG_HOLD = 300;
  localparam int Q1 = 65536;

  // One expected result beat.
  typedef struct packed {
    logic signed [31:0] raw;
    logic signed [31:0] clamped;
    logic               sat;
  } drive_t;

  // The scoreboard keeps its own copy of the gains, the limits and the loop state.
  // When an input beat is accepted, it works out the drive that the beat must
  // produce. When a result beat is taken, it compares that beat with the oldest
  // drive still waiting.
  class drive_scoreboard;
    logic signed [31:0] kp, ki, clamp_lo, clamp_hi;
    logic signed [31:0] integ;
    logic               frozen;
    drive_t             drive_q[$];
    int                 fails;

    function new();
      kp       = PROP_GAIN_RST;
      ki       = '0;
      clamp_lo = DATA_MIN;
      clamp_hi = DATA_MAX;
      integ    = '0;
      frozen   = 1'b0;
      fails    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_PROP_GAIN:  kp = value;
        REG_INTEG_GAIN: ki = value;
        REG_LIMIT_LOW:  clamp_lo = value;
        REG_LIMIT_HIGH: clamp_hi = value;
        default: ;
      endcase
    endfunction

    // Clip a wide signed value to the 32-bit range.
    function logic signed [31:0] clip(logic signed [65:0] v);
      if (v > DATA_MAX) return DATA_MAX;
      if (v < DATA_MIN) return DATA_MIN;
      return v[31:0];
    endfunction

    // Multiply a gain by an operand. The arithmetic shift floors toward minus infinity.
    function logic signed [31:0] scale(logic signed [31:0] gain, logic signed [32:0] x);
      logic signed [65:0] prod;
      prod = gain * x;
      return clip(prod >>> FRAC_W);
    endfunction

    function void note_sample(logic signed [31:0] setpoint, logic signed [31:0] feedback);
      logic signed [32:0] err;
      logic signed [31:0] up;
      logic signed [65:0] wide;
      drive_t             d;
      err = setpoint - feedback;
      up  = scale(kp, err);
      // The integral holds while the previous drive sat on a limit.
      if (!frozen) begin
        wide  = integ + scale(ki, up);
        integ = clip(wide);
      end
      wide  = up + integ;
      d.raw = clip(wide);
      // The upper limit is tested first, which matters when the limits cross.
      if (d.raw > clamp_hi) begin
        d.clamped = clamp_hi;
      end else if (d.raw < clamp_lo) begin
        d.clamped = clamp_lo;
      end else begin
        d.clamped = d.raw;
      end
      d.sat  = (d.clamped != d.raw);
      frozen = d.sat;
      drive_q.push_back(d);
    endfunction

    function void check_result(logic [63:0] data, logic sat);
      drive_t want;
      if (drive_q.size() == 0) begin
        $error("result beat with no expectation waiting: tdata %h tuser %b", data, sat);
        fails++;
        return;
      end
      want = drive_q.pop_front();
      if (data[31:0] !== want.raw) begin
        $error("drive_raw: expected %0d, actual %0d", want.raw, $signed(data[31:0]));
        fails++;
      end
      if (data[63:32] !== want.clamped) begin
        $error("drive_clamped: expected %0d, actual %0d", want.clamped, $signed(data[63:32]));
        fails++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %0b, actual %0b", want.sat, sat);
        fails++;
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // [31:0] setpoint, [63:32] feedback.
  logic [63:0]         in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [31:0] drive_raw, [63:32] drive_clamped.
  logic [63:0]         out_tdata;
  // [0] saturated.
  logic                out_tuser;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  drive_scoreboard sb;
  int  cycle_count = 0;
  // The sender asks for one long hold-off on the result side. The receiver clears the flag.
  bit  hold_req = 1'b0;
  // In the closing stretch neither side idles.
  bit  steady = 1'b0;

  pi_controller_conditional_integration_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[pi_controller_conditional_integration_unit] ERROR");
      $finish;
    end
  end

  // Result monitor. Signals read right after the edge still hold their values from
  // before the edge, so a beat is taken exactly when both handshake lines were high.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
    end
  end

  // Result receiver. It mixes random bursts of ready and stall cycles and serves the
  // one long hold-off that the sender asks for. The receiver stays ready throughout
  // the closing stretch.
  initial begin : receiver
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Offer one sample beat, sometimes after an idle burst, and wait until it is taken.
  // With no gap, tvalid stays high from the previous beat and only tdata changes.
  task automatic send_sample(input logic [31:0] setpoint, input logic [31:0] feedback);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {feedback, setpoint};
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.note_sample(setpoint, feedback);
  endtask

  // Stop offering and wait until every expected result beat has been taken.
  // Each sample yields a result, so the block is idle once the queue is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One APB write: a setup cycle, then an access cycle that completes on pready.
  // psel stays high so that a following write can start its setup at once.
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    sb.set_reg(idx, value);
  endtask

  // Drain the block, then write all four registers.
  task automatic program_regs(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] lo, input logic [31:0] hi);
    settle();
    apb_write(REG_PROP_GAIN, kp);
    apb_write(REG_INTEG_GAIN, ki);
    apb_write(REG_LIMIT_LOW, lo);
    apb_write(REG_LIMIT_HIGH, hi);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Uniform value in [-whole, +whole], in Q16.16.
  function automatic logic [31:0] rand_q16(input int unsigned whole);
    logic [31:0] mag;
    mag = $urandom_range(0, whole * Q1);
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return DATA_MAX;
      1:       return DATA_MIN;
      2:       return 32'd0;
      3:       return 32'd1;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin : main
    logic [31:0] sp, fb, a, b, kp, ki;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unity proportional gain, no integral, full output range.
    // The extreme errors saturate the proportional term in both directions.
    send_sample(32'd0, 32'd0);
    send_sample(DATA_MAX, DATA_MIN);
    send_sample(DATA_MIN, DATA_MAX);
    send_sample(DATA_MAX, DATA_MAX);
    send_sample(32'd1, 32'd0);
    send_sample(32'd0, 32'd1);

    // Gain 1.5 and integral gain 0.5 within +/-100. A one-LSB negative error floors
    // to -2. The drive then runs into the upper limit, the integral freezes,
    // recovers, and the drive finally sits on the lower limit.
    program_regs(32'h0001_8000, 32'h0000_8000, -(100 * Q1), 100 * Q1);
    send_sample(32'd0, 32'd1);
    repeat (3) send_sample(40 * Q1, 32'd0);
    repeat (2) send_sample(32'd0, 40 * Q1);
    repeat (2) send_sample(32'd0, 80 * Q1);

    // Crossed limits with extreme gains. The upper limit (-100) wins over the lower one (+100).
    program_regs(DATA_MAX, DATA_MIN, 100 * Q1, -(100 * Q1));
    send_sample(DATA_MAX, DATA_MIN);
    send_sample(32'd0, 32'd0);
    send_sample(DATA_MIN, DATA_MAX);
    send_sample(32'd1, 32'd0);
    send_sample(32'd0, 32'd1);

    // Opposite extremes, and the limits are crossed as far as they can go.
    program_regs(DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN);
    send_sample(DATA_MAX, DATA_MIN);
    send_sample(DATA_MIN, DATA_MAX);
    send_sample(32'd0, 32'd0);
    send_sample(32'hFFFF_FFFF, 32'd0);

    // Random phases, each with its own register setting. Most phases use moderate
    // gains and ordered limits so that the integral winds up, freezes and recovers.
    // One phase uses full-range random gains, and one uses crossed limits.
    for (int ph = 0; ph < 7; ph++) begin
      kp = rand_q16(4);
      ki = rand_q16(1);
      a  = rand_q16(300);
      b  = rand_q16(300);
      if (ph == 2) begin
        program_regs($urandom, $urandom, DATA_MIN, DATA_MAX);
      end else if (ph == 4) begin
        program_regs(kp, ki, ($signed(a) > $signed(b)) ? a : b,
                     ($signed(a) > $signed(b)) ? b : a);
      end else begin
        program_regs(kp, ki, ($signed(a) > $signed(b)) ? b : a,
                     ($signed(a) > $signed(b)) ? a : b);
      end
      steady = (ph == 6);
      for (int i = 0; i < 100; i++) begin
        // Early in the first random phase the receiver stalls for a long time while
        // samples keep coming, so that the block backs up and drops in_tready.
        if (ph == 0 && i == 10) hold_req = 1'b1;
        case ($urandom_range(0, 9))
          0: begin
            sp = $urandom;
            fb = $urandom;
          end
          1: begin
            sp = corner_value();
            fb = corner_value();
          end
          default: begin
            sp = rand_q16(500);
            fb = sp + rand_q16(20);
          end
        endcase
        send_sample(sp, fb);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected result beats never arrived", sb.pending());
    end
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("[pi_controller_conditional_integration_unit] OK");
    end else begin
      $display("[pi_controller_conditional_integration_unit] ERROR");
    end
    $finish;
  end

endmodule
